>>> hdl/tsn_pkg.sv
// ============================================================================
// tsn_pkg
// Shared constants and types for the thrust saturation normalizer.
// ============================================================================
package tsn_pkg;

  // Set size and derived widths
  localparam int MaxThrusters = 16;
  localparam int IdxW         = $clog2(MaxThrusters);
  localparam int CntW         = $clog2(MaxThrusters + 1);

  // Field widths
  localparam int ForceW = 32;
  localparam int LimitW = 31;
  localparam int EffW   = 32;

  // Divider geometry: dividend is a 32-bit magnitude shifted up by 16
  localparam int FracW = 16;
  localparam int DvdW  = EffW + FracW;
  localparam int DvsW  = 32;

  // Packed stream widths, rounded to whole bytes
  localparam int InDataW  = ((ForceW + 2 * LimitW + 7) / 8) * 8;
  localparam int OutDataW = ((EffW + 4 + 7) / 8) * 8;

  // Q16.16 constants
  localparam logic [EffW-1:0] OneQ16  = 32'h0001_0000;
  localparam logic [EffW-1:0] PosSat  = 32'h7FFF_FFFF;
  localparam logic [EffW-1:0] NegSat  = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NORM,
    S_LOAD,
    S_SCALE,
    S_OUT
  } tsn_state_e;

endpackage

>>> hdl/tsn_div.sv
// ============================================================================
// tsn_div
// Restoring divider, one quotient bit per cycle, shared by the normalize
// and the scaling passes.
// ============================================================================
module tsn_div
  import tsn_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int StepW = $clog2(DvdW + 1);
  localparam logic [StepW-1:0] Steps = StepW'(DvdW);

  logic [DvsW-1:0]  rem_q, rem_d;
  logic [DvdW-1:0]  quo_q, quo_d;
  logic [DvsW-1:0]  dvs_q, dvs_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DvsW:0]    trial;
  logic [DvsW:0]    shifted;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[DvdW-1]};
    trial   = shifted - {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = Steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DvsW]) begin
        rem_d = trial[DvsW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DvsW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/thrust_saturation_normalizer.sv
// ============================================================================
// thrust_saturation_normalizer
// Normalizes thruster forces by their sign-matched limit, tracks the peak
// efforts and emits the whole set, rescaled if a peak is above 1.0.
// ============================================================================
//
// Channel   Dir  Beat contents
// s_axis    in   tdata: force[31:0], fwd limit[62:32], rev limit[93:63];
//                tlast: last thruster of the set
// m_axis    out  tdata: effort[31:0], thruster index[35:32]; tlast: last effort
//
// Each of up to 16 thrusters per set is normalized by the 48-step bit-serial divider.
// On the last thruster the set is emitted, each effort going through S_LOAD,
// then S_SCALE when scaling is needed, then S_OUT, where output stalls hold it.
// s_axis_tready is high only while idle; nothing is accepted during emission.
// Reset clears the count and both peaks; stored efforts need no clearing.
// A stalled output beat holds until taken.
module thrust_saturation_normalizer
  import tsn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // force, forward_limit, reverse_limit, pad
  input  logic                s_axis_tlast,   // last_thruster
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // effort, thruster_index, pad
  output logic                m_axis_tlast    // last_effort
);

  tsn_state_e state_q, state_d;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [EffW-1:0]   fpeak_q, fpeak_d;
  logic [EffW-1:0]   rpeak_q, rpeak_d;
  logic              last_q, last_d;
  logic              neg_q, neg_d;
  logic [EffW-1:0]   eff_q, eff_d;
  logic [EffW-1:0]   buf_q [MaxThrusters];

  logic              buf_we;
  logic [EffW-1:0]   buf_wdata;

  logic              div_start;
  logic [DvdW-1:0]   div_dvd;
  logic [DvsW-1:0]   div_dvs;
  logic              div_done;
  logic [DvdW-1:0]   div_quo;

  logic              in_beat;
  logic [ForceW-1:0] in_force;
  logic [LimitW-1:0] in_flim;
  logic [LimitW-1:0] in_rlim;
  logic              in_neg;
  logic [EffW-1:0]   in_mag;
  logic [LimitW-1:0] in_lim;

  logic [EffW-1:0]   sat_mag;
  logic [EffW-1:0]   rd_eff;
  logic              rd_neg;
  logic [EffW-1:0]   rd_mag;
  logic              scale_en;
  logic [EffW-1:0]   scale_dvs;
  logic              out_last;

  // Input unpacking
  assign in_force = s_axis_tdata[ForceW-1:0];
  assign in_flim  = s_axis_tdata[ForceW+LimitW-1:ForceW];
  assign in_rlim  = s_axis_tdata[ForceW+2*LimitW-1:ForceW+LimitW];
  assign in_neg   = in_force[ForceW-1];
  assign in_mag   = in_neg ? (~in_force + 1'b1) : in_force;
  assign in_lim   = in_neg ? in_rlim : in_flim;
  assign in_beat  = s_axis_tvalid && s_axis_tready;

  // Saturate the normalize quotient by sign
  always_comb begin
    if (neg_q) begin
      sat_mag = (div_quo > {{FracW{1'b0}}, NegSat}) ? NegSat : div_quo[EffW-1:0];
    end else begin
      sat_mag = (div_quo > {{FracW{1'b0}}, PosSat}) ? PosSat : div_quo[EffW-1:0];
    end
  end

  // Scale divisor from the peaks
  always_comb begin
    scale_en  = 1'b0;
    scale_dvs = rpeak_q;
    if (fpeak_q > OneQ16 && fpeak_q > rpeak_q) begin
      scale_en  = 1'b1;
      scale_dvs = fpeak_q;
    end else if (rpeak_q > OneQ16) begin
      scale_en  = 1'b1;
    end
  end

  // Stored effort read
  assign rd_eff   = buf_q[idx_q];
  assign rd_neg   = rd_eff[EffW-1];
  assign rd_mag   = rd_neg ? (~rd_eff + 1'b1) : rd_eff;
  assign out_last = ({1'b0, idx_q} + 1'b1) == cnt_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    fpeak_d   = fpeak_q;
    rpeak_d   = rpeak_q;
    last_d    = last_q;
    neg_d     = neg_q;
    eff_d     = eff_q;
    buf_we    = 1'b0;
    buf_wdata = neg_q ? (~sat_mag + 1'b1) : sat_mag;
    div_start = 1'b0;
    div_dvd   = {in_mag, {FracW{1'b0}}};
    div_dvs   = {1'b0, (in_lim == '0) ? LimitW'(1) : in_lim};
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          last_d = s_axis_tlast;
          neg_d  = in_neg;
          if (cnt_q < CntW'(MaxThrusters)) begin
            div_start = 1'b1;
            state_d   = S_NORM;
          end else if (s_axis_tlast) begin
            idx_d   = '0;
            state_d = S_LOAD;
          end
        end
      end
      S_NORM: begin
        if (div_done) begin
          buf_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (neg_q) begin
            if (sat_mag > rpeak_q) rpeak_d = sat_mag;
          end else begin
            if (sat_mag > fpeak_q) fpeak_d = sat_mag;
          end
          if (last_q) begin
            idx_d   = '0;
            state_d = S_LOAD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        neg_d = rd_neg;
        if (scale_en) begin
          div_dvd   = {rd_mag, {FracW{1'b0}}};
          div_dvs   = scale_dvs;
          div_start = 1'b1;
          state_d   = S_SCALE;
        end else begin
          eff_d   = rd_eff;
          state_d = S_OUT;
        end
      end
      S_SCALE: begin
        if (div_done) begin
          eff_d   = neg_q ? (~div_quo[EffW-1:0] + 1'b1) : div_quo[EffW-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (m_axis_tready) begin
          if (out_last) begin
            cnt_d   = '0;
            fpeak_d = '0;
            rpeak_d = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      fpeak_q <= '0;
      rpeak_q <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      fpeak_q <= fpeak_d;
      rpeak_q <= rpeak_d;
      last_q  <= last_d;
    end
  end

  // Payload registers and effort store
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    eff_q <= eff_d;
    if (buf_we) begin
      buf_q[cnt_q[IdxW-1:0]] <= buf_wdata;
    end
  end

  tsn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Output beat
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {{(OutDataW-EffW-IdxW){1'b0}}, idx_q, eff_q};
  assign m_axis_tlast  = out_last;

endmodule

>>> hdl/tsn_checker.sv
// ============================================================================
// tsn_checker
// Port-level checks on the thrust saturation normalizer.
// ============================================================================
module tsn_checker
  import tsn_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // Output beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output beat changed while stalled");

  // Input and output never open together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during emission");

  // A thruster without the last flag produces no output beat next
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tlast) |=> !m_axis_tvalid)
    else $error("output without last thruster");

  // Index does not restart at zero after a non-last beat of a run
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> ##1
      (!m_axis_tvalid || m_axis_tdata[EffW+IdxW-1:EffW] != '0))
    else $error("index restarted within a run");

endmodule

bind thrust_saturation_normalizer tsn_checker u_tsn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
